[hdl/intc32_pkg.sv]
// intc32_pkg: beat types and register offsets for the 32-line interrupt controller
// no dependencies; used by interrupt_controller_32_line and its checker
`timescale 1ns / 1ps

package intc32_pkg;

   // request kinds
   localparam logic [1:0] KIND_RAISE = 2'd0;
   localparam logic [1:0] KIND_LOWER = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_WRITE = 2'd3;

   // register window offsets
   localparam logic [11:0] OFS_STATUS      = 12'h000;
   localparam logic [11:0] OFS_NUMBER      = 12'h004;
   localparam logic [11:0] OFS_DISABLE_ALL = 12'h008;
   localparam logic [11:0] OFS_DISABLE     = 12'h00c;
   localparam logic [11:0] OFS_ENABLE      = 12'h010;

   localparam int unsigned COUNT_W = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  line_index;
      logic [11:0] bus_offset;
      logic [31:0] write_data;
   } intc_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        bad_offset;
      logic        irq_out;
   } intc_rsp_type;

endpackage

[hdl/interrupt_controller_32_line.sv]
// interrupt_controller_32_line: line latching, enable mask, pending count and irq
// depends on intc32_pkg
`timescale 1ns / 1ps

// One beat is taken on every clock at which start is high; busy never rises,
// so line events and bus accesses can follow one another without gaps. Each
// beat is registered, then processed against the stored masks and count in the
// next cycle. Its result is registered in rsp_ff and is on the result ports for
// exactly one cycle with rsp_strobe high. The receiver has no way to stall: a
// result not captured in its strobe cycle is gone. Beats are handled strictly
// in order, so a read sees every earlier raise, lower and write.
module interrupt_controller_32_line #(
   parameter int unsigned NUM_LINES = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  intc32_pkg::intc_req_type req_data,
   output logic                     rsp_strobe,
   output intc32_pkg::intc_rsp_type rsp_data
);

   // input register stage
   logic                     req_valid_ff;
   intc32_pkg::intc_req_type req_ff;

   // controller state
   logic [NUM_LINES-1:0]            levels_ff, levels_in;
   logic [NUM_LINES-1:0]            enables_ff, enables_in;
   logic [intc32_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                            irq_ff, irq_in;

   // result register stage
   logic                     rsp_strobe_ff;
   intc32_pkg::intc_rsp_type rsp_ff, rsp_in;

   // one-hot selects for the event line and the bus write line
   logic [NUM_LINES-1:0] evt_mask;
   logic [NUM_LINES-1:0] wr_mask;
   logic [NUM_LINES-1:0] pend;
   logic [4:0]           lowest;
   logic                 evt_hit;
   logic                 wr_hit;

   // no back-pressure: every start is taken
   assign busy = 1'b0;

   always_comb begin
      for (int i = 0; i < NUM_LINES; i++) begin
         evt_mask[i] = (req_ff.line_index == 5'(i));
         wr_mask[i]  = (req_ff.write_data[4:0] == 5'(i));
      end
   end

   // lowest pending line, 0 when nothing pending
   assign pend = levels_ff & enables_ff;
   always_comb begin
      lowest = '0;
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         if (pend[i]) begin
            lowest = 5'(i);
         end
      end
   end

   assign evt_hit = |evt_mask;
   assign wr_hit  = |wr_mask;

   always_comb begin
      levels_in  = levels_ff;
      enables_in = enables_ff;
      count_in   = count_ff;
      irq_in     = irq_ff;
      rsp_in.read_data  = '0;
      rsp_in.bad_offset = 1'b0;

      if (req_valid_ff) begin
         case (req_ff.req_type)
            intc32_pkg::KIND_RAISE: begin
               // only an enabled line that is not yet latched counts
               if (evt_hit && ((levels_ff & evt_mask) == '0) &&
                   ((enables_ff & evt_mask) != '0)) begin
                  if (count_ff != intc32_pkg::COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  levels_in = levels_ff | evt_mask;
                  irq_in    = |(levels_in & enables_ff);
               end
            end
            intc32_pkg::KIND_LOWER: begin
               if ((levels_ff & evt_mask) != '0) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
                  levels_in = levels_ff & ~evt_mask;
                  irq_in    = |(levels_in & enables_ff);
               end
            end
            intc32_pkg::KIND_READ: begin
               case (req_ff.bus_offset)
                  intc32_pkg::OFS_STATUS: rsp_in.read_data = 32'(count_ff);
                  intc32_pkg::OFS_NUMBER: rsp_in.read_data = 32'(lowest);
                  default:                rsp_in.bad_offset = 1'b1;
               endcase
            end
            default: begin
               // bus write: irq left as it stands
               case (req_ff.bus_offset)
                  intc32_pkg::OFS_DISABLE_ALL: begin
                     count_in  = '0;
                     levels_in = '0;
                  end
                  intc32_pkg::OFS_DISABLE: begin
                     if ((enables_ff & wr_mask) != '0) begin
                        if (((levels_ff & wr_mask) != '0) && (count_ff != '0)) begin
                           count_in = count_ff - 1'b1;
                        end
                        enables_in = enables_ff & ~wr_mask;
                     end
                  end
                  intc32_pkg::OFS_ENABLE: begin
                     if (wr_hit && ((enables_ff & wr_mask) == '0)) begin
                        enables_in = enables_ff | wr_mask;
                        if (((levels_ff & wr_mask) != '0) &&
                            (count_ff != intc32_pkg::COUNT_MAX)) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  default: rsp_in.bad_offset = 1'b1;
               endcase
            end
         endcase
      end
      rsp_in.irq_out = irq_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         levels_ff     <= '0;
         enables_ff    <= '0;
         count_ff      <= '0;
         irq_ff        <= 1'b0;
      end else begin
         req_valid_ff  <= start && !busy;
         rsp_strobe_ff <= req_valid_ff;
         levels_ff     <= levels_in;
         enables_ff    <= enables_in;
         count_ff      <= count_in;
         irq_ff        <= irq_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hdl/intc32_checker.sv]
// intc32_checker: port-level properties of the interrupt controller
// depends on intc32_pkg; bound to interrupt_controller_32_line
`timescale 1ns / 1ps

module intc32_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input intc32_pkg::intc_req_type req_data,
   input logic                     rsp_strobe,
   input intc32_pkg::intc_rsp_type rsp_data
);

   // every accepted beat gives one result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted beat gave no result");

   // no result without a matching accepted beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a matching beat");

   // a flagged access never returns data
   a_bad_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.bad_offset) |-> (rsp_data.read_data == 32'd0))
      else $error("bad offset with non-zero read data");

   // line events never report a bad offset
   a_event_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(start && !busy && !req_data.req_type[1], 2))
      |-> (!rsp_data.bad_offset && rsp_data.read_data == 32'd0))
      else $error("line event result carries bus status");

endmodule

bind interrupt_controller_32_line intc32_checker u_intc32_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[dv/interrupt_controller_32_line_tb.sv]
// interrupt_controller_32_line_tb: self-checking bench for the 32-line interrupt controller
// drives line events and bus accesses, predicts every result beat and compares it
// depends on intc32_pkg and interrupt_controller_32_line
`timescale 1ns / 1ps

module interrupt_controller_32_line_tb;

   localparam int unsigned LINE_COUNT   = 32;
   localparam int unsigned RANDOM_BEATS = 950;
   localparam int unsigned CYCLE_LIMIT  = 50000;
   localparam int unsigned IDLE_PCT     = 11;
   localparam int unsigned QUIET_FIRST  = 300;   // no sender gaps for beats in this window
   localparam int unsigned QUIET_LAST   = 500;
   localparam int unsigned TAIL_CYCLES  = 6;
   localparam logic [11:0] OFS_TOP      = 12'hfff;
   localparam logic [11:0] OFS_ODD      = 12'h001;

   typedef struct {
      intc32_pkg::intc_req_type beat;
      bit                       settle_first;   // hold this beat back until nothing is outstanding
   } queued_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   intc32_pkg::intc_req_type req_data = '0;
   logic                     rsp_strobe;
   intc32_pkg::intc_rsp_type rsp_data;

   queued_beat_type          queued_beats[$];
   intc32_pkg::intc_rsp_type due_rsps[$];
   bit                       beat_taken = 1'b0;
   int unsigned              beats_sent = 0;
   int unsigned              cycle_count = 0;
   int unsigned              error_count = 0;

   // shadow of the controller state
   logic [31:0]                    latched_lines = '0;
   logic [31:0]                    enabled_lines = '0;
   logic [intc32_pkg::COUNT_W-1:0] shadow_total = '0;
   logic                           irq_level = 1'b0;

   interrupt_controller_32_line u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one-hot select for a line number, empty when the line is out of range
   function automatic logic [31:0] line_mask(logic [4:0] sel);
      if (sel >= LINE_COUNT) return '0;
      return 32'd1 << sel;
   endfunction

   // apply one beat to the shadow state and return the result it should produce
   function automatic intc32_pkg::intc_rsp_type update_lines(intc32_pkg::intc_req_type b);
      intc32_pkg::intc_rsp_type r;
      logic [31:0]              m;
      logic [31:0]              live;
      r = '0;
      case (b.req_type)
         intc32_pkg::KIND_RAISE: begin
            m = line_mask(b.line_index);
            if (m != 0 && (latched_lines & m) == 0 && (enabled_lines & m) != 0) begin
               if (shadow_total != intc32_pkg::COUNT_MAX)
                  shadow_total = shadow_total + 1'b1;
               latched_lines = latched_lines | m;
               irq_level = (latched_lines & enabled_lines) != 0;
            end
         end
         intc32_pkg::KIND_LOWER: begin
            m = line_mask(b.line_index);
            if ((latched_lines & m) != 0) begin
               // count floors at zero
               if (shadow_total != 0) shadow_total = shadow_total - 1'b1;
               latched_lines = latched_lines & ~m;
               irq_level = (latched_lines & enabled_lines) != 0;
            end
         end
         intc32_pkg::KIND_READ: begin
            if (b.bus_offset == intc32_pkg::OFS_STATUS) begin
               r.read_data = 32'(shadow_total);
            end else if (b.bus_offset == intc32_pkg::OFS_NUMBER) begin
               // lowest latched and enabled line, zero when there is none
               live = latched_lines & enabled_lines;
               for (int i = LINE_COUNT - 1; i >= 0; i--)
                  if (live[i]) r.read_data = 32'(i);
            end else begin
               r.bad_offset = 1'b1;
            end
         end
         default: begin
            // bus writes never touch the irq level
            m = line_mask(b.write_data[4:0]);
            if (b.bus_offset == intc32_pkg::OFS_DISABLE_ALL) begin
               shadow_total  = '0;
               latched_lines = '0;
            end else if (b.bus_offset == intc32_pkg::OFS_DISABLE) begin
               if ((enabled_lines & m) != 0) begin
                  if ((latched_lines & m) != 0 && shadow_total != 0)
                     shadow_total = shadow_total - 1'b1;
                  enabled_lines = enabled_lines & ~m;
               end
            end else if (b.bus_offset == intc32_pkg::OFS_ENABLE) begin
               if (m != 0 && (enabled_lines & m) == 0) begin
                  enabled_lines = enabled_lines | m;
                  if ((latched_lines & m) != 0 && shadow_total != intc32_pkg::COUNT_MAX)
                     shadow_total = shadow_total + 1'b1;
               end
            end else begin
               r.bad_offset = 1'b1;
            end
         end
      endcase
      r.irq_out = irq_level;
      return r;
   endfunction

   task automatic add_beat(logic [1:0] kind, logic [4:0] line, logic [11:0] ofs,
                           logic [31:0] data, bit settle = 1'b0);
      queued_beat_type q;
      q.beat.req_type   = kind;
      q.beat.line_index = line;
      q.beat.bus_offset = ofs;
      q.beat.write_data = data;
      q.settle_first    = settle;
      queued_beats.push_back(q);
   endtask

   // driver: new beats go out on the falling edge once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !beat_taken) begin
         // beat still waiting on busy, hold it
      end else begin
         beat_taken = 1'b0;
         if (queued_beats.size() == 0) begin
            start <= 1'b0;
         end else if (queued_beats[0].settle_first && due_rsps.size() != 0) begin
            // let the pipeline drain completely before this beat
            start <= 1'b0;
         end else if (!(beats_sent >= QUIET_FIRST && beats_sent < QUIET_LAST) &&
                      $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
         end else begin
            req_data <= queued_beats[0].beat;
            start    <= 1'b1;
            void'(queued_beats.pop_front());
            beats_sent++;
         end
      end
   end

   // monitor: check the result beat, then record any beat accepted at this edge
   always @(posedge clock) begin : monitor
      intc32_pkg::intc_rsp_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (due_rsps.size() == 0) begin
               $error("result beat with nothing outstanding: %h", rsp_data);
               error_count++;
            end else begin
               want = due_rsps.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data expected %h actual %h", want.read_data,
                         rsp_data.read_data);
                  error_count++;
               end
               if (rsp_data.bad_offset !== want.bad_offset) begin
                  $error("bad_offset expected %b actual %b", want.bad_offset,
                         rsp_data.bad_offset);
                  error_count++;
               end
               if (rsp_data.irq_out !== want.irq_out) begin
                  $error("irq_out expected %b actual %b", want.irq_out, rsp_data.irq_out);
                  error_count++;
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe unknown");
            error_count++;
         end
         if (start && busy === 1'b0) begin
            due_rsps.push_back(update_lines(req_data));
            beat_taken = 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [1:0]  kind;
      logic [11:0] ofs;
      int unsigned pick;

      // directed: disabled line, enables with upper data bits set, duplicates,
      // lowest-line reads, count floor, stale irq after writes, undefined offsets
      add_beat(intc32_pkg::KIND_RAISE, 5'd5, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_STATUS, 32'hffff_ffff);
      add_beat(intc32_pkg::KIND_READ, 5'd31, intc32_pkg::OFS_NUMBER, 32'd0);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, intc32_pkg::OFS_ENABLE, 32'hffff_ffe0);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, intc32_pkg::OFS_ENABLE, 32'h0000_001f);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, intc32_pkg::OFS_ENABLE, 32'h0000_0005);
      add_beat(intc32_pkg::KIND_RAISE, 5'd31, OFS_TOP, 32'hffff_ffff);
      add_beat(intc32_pkg::KIND_RAISE, 5'd0, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_RAISE, 5'd0, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_NUMBER, 32'd0);
      add_beat(intc32_pkg::KIND_LOWER, 5'd0, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_NUMBER, 32'd0);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, intc32_pkg::OFS_DISABLE, 32'h8000_001f);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_NUMBER, 32'd0);
      add_beat(intc32_pkg::KIND_LOWER, 5'd31, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_LOWER, 5'd31, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_DISABLE_ALL, 32'd0, 1'b1);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, intc32_pkg::OFS_STATUS, 32'h0000_0005);
      add_beat(intc32_pkg::KIND_READ, 5'd0, OFS_TOP, 32'd0);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, OFS_ODD, 32'd5);
      add_beat(intc32_pkg::KIND_RAISE, 5'd5, intc32_pkg::OFS_STATUS, 32'd0);
      add_beat(intc32_pkg::KIND_WRITE, 5'd0, intc32_pkg::OFS_DISABLE_ALL, 32'd0);
      add_beat(intc32_pkg::KIND_READ, 5'd0, intc32_pkg::OFS_STATUS, 32'd0);

      // random: mostly legal offsets so lines build up, a few stray ones,
      // and only the odd clear-all so the count gets a chance to climb
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         pick = $urandom_range(99);
         if (pick < 30)      kind = intc32_pkg::KIND_RAISE;
         else if (pick < 50) kind = intc32_pkg::KIND_LOWER;
         else if (pick < 75) kind = intc32_pkg::KIND_READ;
         else                kind = intc32_pkg::KIND_WRITE;
         ofs = 12'($urandom_range(4095));
         if ($urandom_range(9) != 0) begin
            if (kind == intc32_pkg::KIND_READ) begin
               ofs = $urandom_range(1) ? intc32_pkg::OFS_NUMBER : intc32_pkg::OFS_STATUS;
            end else if (kind == intc32_pkg::KIND_WRITE) begin
               pick = $urandom_range(19);
               if (pick == 0)     ofs = intc32_pkg::OFS_DISABLE_ALL;
               else if (pick < 8) ofs = intc32_pkg::OFS_DISABLE;
               else               ofs = intc32_pkg::OFS_ENABLE;
            end
         end
         add_beat(kind, 5'($urandom_range(31)), ofs, $urandom, n == 600);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all beats accepted, then every result in, then a short tail for strays
      while (queued_beats.size() != 0 || start) @(negedge clock);
      while (due_rsps.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
